@@ hdl/cpba_pkg.sv @@
package cpba_pkg;

  // default width of the running token budget and total
  localparam int TOKEN_WIDTH_DEF = 16;

  // field widths
  localparam int TOK_W  = 16;
  localparam int LOG_W  = 4;
  localparam int SEQ_W  = 9;
  localparam int CFG_AW = 2;
  localparam int CFG_DW = 16;

  // configuration register indexes
  localparam logic [CFG_AW-1:0] CFG_TOKEN_BUDGET    = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_CHUNK_CAP       = 2'd1;
  localparam logic [CFG_AW-1:0] CFG_BLOCK_SIZE_LOG2 = 2'd2;
  localparam logic [CFG_AW-1:0] CFG_MAX_BATCH_SEQS  = 2'd3;

  // configuration reset values
  localparam logic [TOK_W-1:0] TOKEN_BUDGET_RST    = 16'd2048;
  localparam logic [TOK_W-1:0] CHUNK_CAP_RST       = 16'd512;
  localparam logic [LOG_W-1:0] BLOCK_SIZE_LOG2_RST = 4'd4;
  localparam logic [SEQ_W-1:0] MAX_BATCH_SEQS_RST  = 9'd64;

  // request modes
  localparam logic MODE_START     = 1'b0;
  localparam logic MODE_CANDIDATE = 1'b1;

  typedef struct packed {
    logic             mode;
    logic [TOK_W-1:0] free_blocks;
    logic [TOK_W-1:0] prompt_len;
    logic [TOK_W-1:0] done_tokens;
    logic [TOK_W-1:0] context_tokens;
    logic             busy_req;
  } in_item_t;

  typedef struct packed {
    logic [TOK_W-1:0] chunk;
    logic             granted;
    logic             closed;
    logic [TOK_W-1:0] batch_tokens;
  } out_item_t;

endpackage

@@ hdl/chunked_prefill_batch_admission_core.sv @@
// chunked prefill batch admission: grants token chunks under token and cache block budgets
// result path: input register, then result register; a result stall holds the input register
// throughput: one request per cycle unless results stall; the budget update is a
//   combinational path: subtract, min selection, block-count shift, saturating subtract
// reset (synchronous, active low): config to defaults, budgets and counts cleared,
//   batch marked closed, pipeline emptied
module chunked_prefill_batch_admission_core #(
  parameter int TOKEN_WIDTH = cpba_pkg::TOKEN_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  cpba_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output cpba_pkg::out_item_t             out_data,
  input  logic                            cfg_we,
  input  logic [cpba_pkg::CFG_AW-1:0]     cfg_addr,
  input  logic [cpba_pkg::CFG_DW-1:0]     cfg_wdata
);

  localparam int TW = TOKEN_WIDTH;
  localparam int CW = (TOKEN_WIDTH > cpba_pkg::TOK_W) ? TOKEN_WIDTH : cpba_pkg::TOK_W;
  localparam int FW = 32;
  localparam int EW = cpba_pkg::TOK_W + 2;

  // configuration registers
  logic [cpba_pkg::TOK_W-1:0] token_budget_r;
  logic [cpba_pkg::TOK_W-1:0] chunk_cap_r;
  logic [cpba_pkg::LOG_W-1:0] block_size_log2_r;
  logic [cpba_pkg::SEQ_W-1:0] max_batch_seqs_r;

  // pipeline registers
  logic                s1_valid_r;
  cpba_pkg::in_item_t  s1_data_r;
  logic                out_valid_r;
  cpba_pkg::out_item_t out_data_r;
  cpba_pkg::out_item_t out_data_nxt;

  // batch state
  logic [TW-1:0]              budget_left_r, budget_left_nxt;
  logic [cpba_pkg::TOK_W-1:0] blocks_left_r, blocks_left_nxt;
  logic [cpba_pkg::SEQ_W-1:0] admitted_r, admitted_nxt;
  logic [TW-1:0]              total_r, total_nxt;
  logic                       closed_r, closed_nxt;

  logic adv;
  logic in_fire;

  // datapath signals
  logic [cpba_pkg::TOK_W-1:0] remain;
  logic                       eligible;
  logic [CW-1:0]              cap_min;
  logic [CW-1:0]              c0;
  logic [cpba_pkg::TOK_W-1:0] c0_t;
  logic [FW-1:0]              bs_mask;
  logic [cpba_pkg::TOK_W-1:0] part;
  logic [cpba_pkg::TOK_W-1:0] room;
  logic [FW-1:0]              fit;
  logic [cpba_pkg::TOK_W-1:0] chunk;
  logic [EW-1:0]              end_cover, start_cover, added;
  logic                       grant;

  // handshake: stage 1 moves on when the result register is free or being drained
  assign adv       = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || adv;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // chunk size: least of remaining prompt, budget, cap and block room
  always_comb begin
    remain   = s1_data_r.prompt_len - s1_data_r.done_tokens;
    eligible = !s1_data_r.busy_req && (s1_data_r.prompt_len > s1_data_r.done_tokens);
    cap_min  = (CW'(budget_left_r) < CW'(chunk_cap_r)) ? CW'(budget_left_r) : CW'(chunk_cap_r);
    c0       = (CW'(remain) < cap_min) ? CW'(remain) : cap_min;
    c0_t     = c0[cpba_pkg::TOK_W-1:0];
    bs_mask  = (FW'(1) << block_size_log2_r) - FW'(1);
    part     = s1_data_r.context_tokens & bs_mask[cpba_pkg::TOK_W-1:0];
    room     = (part != '0) ? (bs_mask[cpba_pkg::TOK_W-1:0] - part + 16'd1) : '0;
    fit      = FW'(room) + (FW'(blocks_left_r) << block_size_log2_r);
    chunk    = (FW'(c0_t) < fit) ? c0_t : fit[cpba_pkg::TOK_W-1:0];
    grant    = eligible && (chunk != '0);
  end

  // cache blocks newly touched by the chunk
  always_comb begin
    end_cover   = (EW'(s1_data_r.context_tokens) + EW'(chunk) +
                   EW'(bs_mask[cpba_pkg::TOK_W-1:0])) >> block_size_log2_r;
    start_cover = (EW'(s1_data_r.context_tokens) +
                   EW'(bs_mask[cpba_pkg::TOK_W-1:0])) >> block_size_log2_r;
    added       = end_cover - start_cover;
  end

  // next batch state and result
  always_comb begin
    budget_left_nxt = budget_left_r;
    blocks_left_nxt = blocks_left_r;
    admitted_nxt    = admitted_r;
    total_nxt       = total_r;
    closed_nxt      = closed_r;
    out_data_nxt.chunk   = '0;
    out_data_nxt.granted = 1'b0;
    if (s1_data_r.mode == cpba_pkg::MODE_START) begin
      blocks_left_nxt = s1_data_r.free_blocks;
      budget_left_nxt = TW'(token_budget_r);
      admitted_nxt    = '0;
      total_nxt       = '0;
      closed_nxt      = (TW'(token_budget_r) == '0) || (max_batch_seqs_r == '0);
    end else if (!closed_r) begin
      if (grant) begin
        blocks_left_nxt = (added > EW'(blocks_left_r)) ? '0 :
                          (blocks_left_r - added[cpba_pkg::TOK_W-1:0]);
        budget_left_nxt = budget_left_r - TW'(chunk);
        total_nxt       = total_r + TW'(chunk);
        admitted_nxt    = admitted_r + 9'd1;
        out_data_nxt.chunk   = chunk;
        out_data_nxt.granted = 1'b1;
      end
      closed_nxt = (budget_left_nxt == '0) || (admitted_nxt >= max_batch_seqs_r);
    end
    out_data_nxt.closed       = closed_nxt;
    out_data_nxt.batch_tokens = cpba_pkg::TOK_W'(total_nxt);
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      token_budget_r    <= cpba_pkg::TOKEN_BUDGET_RST;
      chunk_cap_r       <= cpba_pkg::CHUNK_CAP_RST;
      block_size_log2_r <= cpba_pkg::BLOCK_SIZE_LOG2_RST;
      max_batch_seqs_r  <= cpba_pkg::MAX_BATCH_SEQS_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        cpba_pkg::CFG_TOKEN_BUDGET:    token_budget_r    <= cfg_wdata;
        cpba_pkg::CFG_CHUNK_CAP:       chunk_cap_r       <= cfg_wdata;
        cpba_pkg::CFG_BLOCK_SIZE_LOG2: block_size_log2_r <= cfg_wdata[cpba_pkg::LOG_W-1:0];
        cpba_pkg::CFG_MAX_BATCH_SEQS:  max_batch_seqs_r  <= cfg_wdata[cpba_pkg::SEQ_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (adv) begin
        s1_valid_r <= 1'b0;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_data_r <= in_data;
    end
    if (adv) begin
      out_data_r <= out_data_nxt;
    end
  end

  // batch state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      budget_left_r <= '0;
      blocks_left_r <= '0;
      admitted_r    <= '0;
      total_r       <= '0;
      closed_r      <= 1'b1;
    end else if (adv) begin
      budget_left_r <= budget_left_nxt;
      blocks_left_r <= blocks_left_nxt;
      admitted_r    <= admitted_nxt;
      total_r       <= total_nxt;
      closed_r      <= closed_nxt;
    end
  end

`ifndef SYNTHESIS
  // a granted result always carries a nonzero chunk, a refused one none
  a_grant_chunk: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.granted == (out_data_r.chunk != '0)))
    else $error("granted flag and chunk disagree");

  // each grant admits exactly one more request
  a_admit_count: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && s1_data_r.mode == cpba_pkg::MODE_CANDIDATE && !closed_r && grant) |=>
    (admitted_r == $past(admitted_r) + 9'd1))
    else $error("admitted count did not follow grant");

  // a closed batch reopens only through a start request
  a_stay_closed: assert property (@(posedge clk) disable iff (!rst_n)
    (closed_r && !(adv && s1_data_r.mode == cpba_pkg::MODE_START)) |=> closed_r)
    else $error("batch reopened without start");

  // block budget only grows on a start request
  a_blocks_mono: assert property (@(posedge clk) disable iff (!rst_n)
    !(adv && s1_data_r.mode == cpba_pkg::MODE_START) |=>
    (blocks_left_r <= $past(blocks_left_r)))
    else $error("block budget grew during a batch");

  // token budget never goes up within a batch
  a_budget_mono: assert property (@(posedge clk) disable iff (!rst_n)
    !(adv && s1_data_r.mode == cpba_pkg::MODE_START) |=>
    (budget_left_r <= $past(budget_left_r)))
    else $error("token budget grew during a batch");
`endif

endmodule

@@ tb/chunked_prefill_batch_admission_core_test.sv @@
module chunked_prefill_batch_admission_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;
  localparam int TARGET_REQUESTS = 450;

  // expected admission decisions, kept in request order
  class admission_scoreboard;
    logic [cpba_pkg::TOK_W-1:0] token_budget;
    logic [cpba_pkg::TOK_W-1:0] chunk_cap;
    logic [cpba_pkg::LOG_W-1:0] blk_log2;
    logic [cpba_pkg::SEQ_W-1:0] max_seqs;
    logic [cpba_pkg::TOK_W-1:0] budget_left;
    logic [cpba_pkg::TOK_W-1:0] blocks_left;
    logic [cpba_pkg::TOK_W-1:0] batch_total;
    logic [cpba_pkg::SEQ_W-1:0] admitted;
    bit closed;
    cpba_pkg::out_item_t expected_grants[$];
    int mismatches;

    function new();
      token_budget = cpba_pkg::TOKEN_BUDGET_RST;
      chunk_cap = cpba_pkg::CHUNK_CAP_RST;
      blk_log2 = cpba_pkg::BLOCK_SIZE_LOG2_RST;
      max_seqs = cpba_pkg::MAX_BATCH_SEQS_RST;
      budget_left = '0;
      blocks_left = '0;
      batch_total = '0;
      admitted = '0;
      closed = 1'b1;
      mismatches = 0;
    endfunction

    function void set_register(logic [cpba_pkg::CFG_AW-1:0] idx,
                               logic [cpba_pkg::CFG_DW-1:0] val);
      case (idx)
        cpba_pkg::CFG_TOKEN_BUDGET: token_budget = val;
        cpba_pkg::CFG_CHUNK_CAP: chunk_cap = val;
        cpba_pkg::CFG_BLOCK_SIZE_LOG2: blk_log2 = val[cpba_pkg::LOG_W-1:0];
        cpba_pkg::CFG_MAX_BATCH_SEQS: max_seqs = val[cpba_pkg::SEQ_W-1:0];
        default: ;
      endcase
    endfunction

    function bit batch_full();
      return budget_left == 0 || admitted >= max_seqs;
    endfunction

    function longint unsigned blocks_spanned(longint unsigned tokens, int unsigned lg);
      return (tokens + (64'd1 << lg) - 64'd1) >> lg;
    endfunction

    // work out the decision for one accepted request
    function void note_request(cpba_pkg::in_item_t r);
      cpba_pkg::out_item_t e;
      longint unsigned want, part, room, fit, bs, added;
      int unsigned lg;
      e = '0;
      if (r.mode == cpba_pkg::MODE_START) begin
        blocks_left = r.free_blocks;
        budget_left = token_budget;
        admitted = '0;
        batch_total = '0;
        closed = batch_full();
      end else if (!closed) begin
        if (!r.busy_req && r.prompt_len > r.done_tokens) begin
          lg = 32'(blk_log2);
          bs = 64'd1 << lg;
          want = 64'(r.prompt_len) - 64'(r.done_tokens);
          if (64'(budget_left) < want) want = 64'(budget_left);
          if (64'(chunk_cap) < want) want = 64'(chunk_cap);
          // room left in the partly filled last block plus whole free blocks
          part = 64'(r.context_tokens) & (bs - 64'd1);
          room = (r.context_tokens != 0 && part != 0) ? bs - part : 64'd0;
          fit = room + (64'(blocks_left) << lg);
          if (fit < want) want = fit;
          if (want != 0) begin
            added = blocks_spanned(64'(r.context_tokens) + want, lg) -
                    blocks_spanned(64'(r.context_tokens), lg);
            if (added > 64'(blocks_left)) blocks_left = '0;
            else blocks_left = blocks_left - added[cpba_pkg::TOK_W-1:0];
            budget_left = budget_left - want[cpba_pkg::TOK_W-1:0];
            batch_total = batch_total + want[cpba_pkg::TOK_W-1:0];
            admitted = admitted + 1'b1;
            e.chunk = want[cpba_pkg::TOK_W-1:0];
            e.granted = 1'b1;
          end
        end
        closed = batch_full();
      end
      e.closed = closed;
      e.batch_tokens = batch_total;
      expected_grants = {expected_grants, e};
    endfunction

    task report_mismatch(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      mismatches++;
    endtask

    // compare one decision against the oldest expectation
    task check_decision(cpba_pkg::out_item_t got);
      cpba_pkg::out_item_t e;
      if (expected_grants.size() == 0) begin
        report_mismatch("decision with no request pending");
        return;
      end
      e = expected_grants[0];
      expected_grants.delete(0);
      if (got.chunk !== e.chunk)
        report_mismatch($sformatf("chunk %0d, expected %0d", got.chunk, e.chunk));
      if (got.granted !== e.granted)
        report_mismatch($sformatf("granted %0b, expected %0b", got.granted, e.granted));
      if (got.closed !== e.closed)
        report_mismatch($sformatf("closed %0b, expected %0b", got.closed, e.closed));
      if (got.batch_tokens !== e.batch_tokens)
        report_mismatch($sformatf("batch_tokens %0d, expected %0d",
                                  got.batch_tokens, e.batch_tokens));
    endtask

    function int pending();
      return expected_grants.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  cpba_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  cpba_pkg::out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [cpba_pkg::CFG_AW-1:0] cfg_addr = '0;
  logic [cpba_pkg::CFG_DW-1:0] cfg_wdata = '0;

  admission_scoreboard sb;
  bit calm = 1'b0;
  int hold_off_cycles = 0;
  int cycle_count = 0;

  chunked_prefill_batch_admission_core dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_addr(cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("chunked_prefill_batch_admission_core_test: done, errors");
      $finish;
    end
  end

  // result side: check accepted decisions, stall at random or for a long hold-off
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_decision(out_data);
    if (hold_off_cycles > 0) begin
      hold_off_cycles--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || $urandom_range(99) >= 15;
    end
  end

  // offer one request and hold it until accepted
  task automatic send_request(input cpba_pkg::in_item_t r);
    while (!calm && $urandom_range(99) < 15) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_request(r);
  endtask

  // stop offering and wait until every expected decision has come back
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // write all four registers once the block has gone idle
  task automatic apply_settings(int unsigned budget, int unsigned cap, int unsigned lg,
                                int unsigned seqs);
    logic [cpba_pkg::CFG_AW-1:0] idx [4];
    logic [cpba_pkg::CFG_DW-1:0] val [4];
    idx = '{cpba_pkg::CFG_TOKEN_BUDGET, cpba_pkg::CFG_CHUNK_CAP,
            cpba_pkg::CFG_BLOCK_SIZE_LOG2, cpba_pkg::CFG_MAX_BATCH_SEQS};
    val = '{16'(budget), 16'(cap), 16'(lg), 16'(seqs)};
    wait_results_drained();
    foreach (idx[i]) begin
      cfg_we <= 1'b1;
      cfg_addr <= idx[i];
      cfg_wdata <= val[i];
      @(posedge clk);
      sb.set_register(idx[i], val[i]);
    end
    cfg_we <= 1'b0;
  endtask

  function automatic cpba_pkg::in_item_t batch_start(int unsigned free);
    cpba_pkg::in_item_t r;
    r.mode = cpba_pkg::MODE_START;
    r.free_blocks = 16'(free);
    r.prompt_len = 16'($urandom());
    r.done_tokens = 16'($urandom());
    r.context_tokens = 16'($urandom());
    r.busy_req = 1'($urandom_range(1));
    return r;
  endfunction

  function automatic cpba_pkg::in_item_t candidate(int unsigned prompt, int unsigned done,
                                                   int unsigned ctx, bit busy);
    cpba_pkg::in_item_t r;
    r.mode = cpba_pkg::MODE_CANDIDATE;
    r.free_blocks = 16'($urandom());
    r.prompt_len = 16'(prompt);
    r.done_tokens = 16'(done);
    r.context_tokens = 16'(ctx);
    r.busy_req = busy;
    return r;
  endfunction

  // mostly schedulable candidates, some busy, finished, stray starts or pure noise
  function automatic cpba_pkg::in_item_t random_candidate();
    cpba_pkg::in_item_t r;
    int unsigned pick;
    int unsigned prompt, done, ctx;
    prompt = ($urandom_range(99) < 70) ? $urandom_range(1, 3000) : $urandom_range(1, 65535);
    done = ($urandom_range(3) == 0) ? 0 : $urandom_range(0, prompt - 1);
    ctx = $urandom_range(1) ? done : $urandom_range(0, 65535);
    r = candidate(prompt, done, ctx, 1'b0);
    pick = $urandom_range(99);
    if (pick < 5) begin
      r.busy_req = 1'b1;
    end else if (pick < 9) begin
      r.done_tokens = 16'($urandom_range(prompt, 65535));
    end else if (pick < 11) begin
      r.mode = cpba_pkg::MODE_START;
      r.free_blocks = 16'($urandom_range(0, 400));
    end else if (pick < 14) begin
      r.mode = 1'($urandom_range(1));
      r.prompt_len = 16'($urandom());
      r.done_tokens = 16'($urandom());
      r.context_tokens = 16'($urandom());
      r.busy_req = 1'($urandom_range(1));
    end
    return r;
  endfunction

  function automatic int unsigned random_free_blocks();
    return ($urandom_range(99) < 30) ? $urandom_range(0, 65535) : $urandom_range(0, 300);
  endfunction

  initial begin
    int counted;
    int phase;
    int batches;
    int quota;
    int k;
    sb = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: defaults, candidate before any batch is open
    send_request(candidate(100, 0, 0, 1'b0));
    // no free blocks: only the partly filled block has room
    send_request(batch_start(0));
    send_request(candidate(100, 0, 5, 1'b0));
    send_request(candidate(100, 0, 0, 1'b0));
    send_request(candidate(100, 0, 32, 1'b0));
    // plenty of blocks: chunk cap, skipped requests, budget runs out
    send_request(batch_start(65535));
    send_request(candidate(65535, 0, 65535, 1'b0));
    send_request(candidate(300, 300, 0, 1'b0));
    send_request(candidate(10, 65535, 0, 1'b0));
    send_request(candidate(0, 0, 0, 1'b0));
    send_request(candidate(4000, 100, 100, 1'b1));
    send_request(candidate(65535, 65534, 7, 1'b0));
    send_request(candidate(4000, 0, 0, 1'b0));
    send_request(candidate(4000, 0, 0, 1'b0));
    send_request(candidate(4000, 0, 0, 1'b0));
    send_request(candidate(50, 0, 0, 1'b0));
    // largest settings, block size beyond the usual range, one request per batch
    apply_settings(65535, 65535, 15, 1);
    send_request(batch_start(65535));
    send_request(candidate(65535, 0, 65535, 1'b0));
    send_request(candidate(10, 0, 0, 1'b0));
    // zero token budget: batch born closed
    apply_settings(0, 1, 0, 256);
    send_request(batch_start(3));
    send_request(candidate(5, 0, 0, 1'b0));
    // zero request cap: batch born closed
    apply_settings(1, 1, 0, 0);
    send_request(batch_start(1));
    // single-token blocks, block budget runs out
    apply_settings(5, 1, 0, 256);
    send_request(batch_start(2));
    send_request(candidate(9, 0, 3, 1'b0));
    send_request(candidate(9, 0, 3, 1'b0));
    send_request(candidate(9, 0, 3, 1'b0));

    // random phases of batches under varying settings
    counted = 0;
    phase = 0;
    while (counted < TARGET_REQUESTS) begin
      phase++;
      calm = (phase == 2 || phase == 5);
      apply_settings(($urandom_range(3) == 0) ? $urandom_range(1, 64) :
                     ($urandom_range(2) == 0) ? $urandom_range(1, 65535) :
                     $urandom_range(256, 4096),
                     ($urandom_range(9) < 3) ? $urandom_range(1, 32) :
                     ($urandom_range(9) < 8) ? $urandom_range(64, 1024) :
                     $urandom_range(1, 65535),
                     ($urandom_range(9) < 8) ? $urandom_range(0, 8) : $urandom_range(9, 15),
                     ($urandom_range(9) < 4) ? $urandom_range(1, 8) : $urandom_range(9, 256));
      // receiver holds off while requests keep coming
      if (phase == 5) hold_off_cycles = 250;
      batches = $urandom_range(3, 8);
      for (int b = 0; b < batches; b++) begin
        // the first batch of a phase may carry on under the new settings
        if (b > 0 || $urandom_range(1)) begin
          send_request(batch_start(random_free_blocks()));
          counted++;
        end
        quota = $urandom_range(1, 40);
        k = 0;
        while (!sb.closed && k < quota) begin
          send_request(random_candidate());
          counted++;
          k++;
        end
        repeat ($urandom_range(0, 2)) begin
          send_request(random_candidate());
          counted++;
        end
      end
    end

    calm = 1'b0;
    wait_results_drained();
    repeat (8) @(posedge clk);
    if (sb.mismatches == 0)
      $display("chunked_prefill_batch_admission_core_test: done, clean");
    else
      $display("chunked_prefill_batch_admission_core_test: done, errors");
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/cpba_pkg.sv
hdl/chunked_prefill_batch_admission_core.sv
tb/chunked_prefill_batch_admission_core_test.sv
